// ----- src/tbmwf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbmwf_pkg
// Shared constants and controller/datapath interface types for the
// triple barometer median-weighted fusion core.
// ----------------------------------------------------------------------------
package tbmwf_pkg;

  // EMA: ema' = floor((EMA_KEEP*ema + sample) / EMA_DIV)
  localparam int EMA_KEEP = 9;
  localparam int EMA_DIV  = 10;

  // distance thresholds and the weights they give
  localparam int DIST_NEAR = 20;
  localparam int DIST_MID  = 50;
  localparam int DIST_FAR  = 100;
  localparam int WGT_NEAR  = 100;
  localparam int WGT_MID   = 70;
  localparam int WGT_FAR   = 30;

  localparam int WEIGHT_W = 7;   // holds 0..100
  localparam int WSUM_W   = 9;   // holds 0..300

  typedef struct packed {
    logic load;        // capture samples, form the divide-by-ten dividends
    logic div10_step;  // reciprocal multiply in each EMA lane
    logic ema_upd;     // write back the EMAs of enabled sensors
    logic weigh;       // median, distances and weights
    logic prod;        // weighted products and weight sum
    logic sum;         // accumulate products
    logic divw_init;   // load the weighted-mean divider
    logic divw_step;   // one quotient bit of the weighted mean
    logic out_load;    // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic wsum_zero;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- src/tbmwf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbmwf_ctrl
// Sequencer: steps the datapath through EMA update, weighting and the
// serial weighted-mean divide, and owns both handshakes.
// ----------------------------------------------------------------------------
module tbmwf_ctrl #(
  parameter int PRESSURE_WIDTH = 17
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tbmwf_pkg::dp_cmd_t     cmd,
  input  wire tbmwf_pkg::dp_sts_t sts
);

  localparam int CW = (PRESSURE_WIDTH > 1) ? $clog2(PRESSURE_WIDTH) : 1;
  localparam logic [CW-1:0] LAST = CW'(PRESSURE_WIDTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV10, S_EMA, S_WEIGH, S_PROD, S_SUM, S_DINIT, S_DIVW, S_DONE
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  logic            out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.div10_step = (state == S_DIV10);
    cmd.ema_upd    = (state == S_EMA);
    cmd.weigh      = (state == S_WEIGH);
    cmd.prod       = (state == S_PROD);
    cmd.sum        = (state == S_SUM);
    cmd.divw_init  = (state == S_DINIT);
    cmd.divw_step  = (state == S_DIVW);
    cmd.out_load   = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall)  out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIV10;
            cnt   <= '0;
          end
        end
        S_DIV10: state <= S_EMA;
        S_EMA:   state <= S_WEIGH;
        S_WEIGH: state <= S_PROD;
        S_PROD:  state <= S_SUM;
        S_SUM:   state <= sts.wsum_zero ? S_DONE : S_DINIT;  // held value: no divide
        S_DINIT: begin
          state <= S_DIVW;
          cnt   <= '0;
        end
        S_DIVW: begin
          if (cnt == LAST) begin
            state <= S_DONE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/tbmwf_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbmwf_dp
// Datapath: three EMA lanes with a reciprocal divide by ten, median and
// weighting, product/sum stages and a bit-serial weighted-mean divider.
// ----------------------------------------------------------------------------
module tbmwf_dp #(
  parameter int PRESSURE_WIDTH = 17
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [2:0]                cfg_wr_data,
  input  wire logic [PRESSURE_WIDTH-1:0] pressure_a,
  input  wire logic [PRESSURE_WIDTH-1:0] pressure_b,
  input  wire logic [PRESSURE_WIDTH-1:0] pressure_c,
  input  wire tbmwf_pkg::dp_cmd_t        cmd,
  output tbmwf_pkg::dp_sts_t             sts,
  output logic [PRESSURE_WIDTH-1:0]      fused_value,
  output logic [PRESSURE_WIDTH-1:0]      median_pressure,
  output logic [6:0]                     weight_a,
  output logic [6:0]                     weight_b,
  output logic [6:0]                     weight_c,
  output logic                           fused_updated
);

  localparam int PW  = PRESSURE_WIDTH;
  localparam int DW  = PW + 4;                     // 9*ema + sample
  localparam int WW  = tbmwf_pkg::WEIGHT_W;
  localparam int SW  = tbmwf_pkg::WSUM_W;
  localparam int PRW = PW + WW;                    // one product
  localparam int AW  = PW + SW;                    // sum of three products
  // x / 10 == (x * ceil(2^RSH / 10)) >> RSH for every x below 2^DW
  localparam int RSH = DW + 3;
  localparam logic [63:0] RECIP10_FULL =
    ((64'd1 << RSH) + 64'(tbmwf_pkg::EMA_DIV) - 64'd1) / 64'(tbmwf_pkg::EMA_DIV);
  localparam logic [DW-1:0] RECIP10 = RECIP10_FULL[DW-1:0];

  logic [2:0]    mask;
  logic [PW-1:0] ema        [3];
  logic [PW-1:0] samp       [3];
  logic [PW-1:0] dvd        [3];   // quotient of the divide by ten
  logic [DW-1:0] dnd_q      [3];
  logic [WW-1:0] wgt        [3];
  logic [PRW-1:0] prod      [3];
  logic [PW-1:0] med;
  logic [SW-1:0] wsum;
  logic [AW-1:0] acc;
  logic [SW-1:0] qrem;
  logic [PW-1:0] qdvd;
  logic [PW-1:0] last_fused;

  logic [PW-1:0]   smp_in   [3];
  logic [DW-1:0]   dnd      [3];
  logic [2*DW-1:0] rprod    [3];
  logic [PW-1:0]   med_c;
  logic [PW-1:0]   gap      [3];
  logic [WW-1:0]   wgt_c    [3];
  logic [SW:0]     tw;
  logic            gew;

  assign smp_in[0] = pressure_a;
  assign smp_in[1] = pressure_b;
  assign smp_in[2] = pressure_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dnd[i]   = DW'(tbmwf_pkg::EMA_KEEP) * {4'b0, ema[i]} + {4'b0, smp_in[i]};
      rprod[i] = {{DW{1'b0}}, dnd_q[i]} * {{DW{1'b0}}, RECIP10};
    end
  end

  // median of three
  always_comb begin
    if (ema[0] >= ema[1]) begin
      if (ema[1] >= ema[2])      med_c = ema[1];
      else if (ema[0] >= ema[2]) med_c = ema[2];
      else                       med_c = ema[0];
    end else begin
      if (ema[0] >= ema[2])      med_c = ema[0];
      else if (ema[1] >= ema[2]) med_c = ema[2];
      else                       med_c = ema[1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gap[i] = (ema[i] > med_c) ? (ema[i] - med_c) : (med_c - ema[i]);
      if (!mask[i])                                 wgt_c[i] = '0;
      else if (gap[i] < PW'(tbmwf_pkg::DIST_NEAR))  wgt_c[i] = WW'(tbmwf_pkg::WGT_NEAR);
      else if (gap[i] < PW'(tbmwf_pkg::DIST_MID))   wgt_c[i] = WW'(tbmwf_pkg::WGT_MID);
      else if (gap[i] < PW'(tbmwf_pkg::DIST_FAR))   wgt_c[i] = WW'(tbmwf_pkg::WGT_FAR);
      else                                          wgt_c[i] = '0;
    end
  end

  assign tw  = {qrem, qdvd[PW-1]};
  assign gew = (tw >= {1'b0, wsum});
  assign sts.wsum_zero = (wsum == '0);

  // control state: enable mask, EMAs and the held fused value
  always_ff @(posedge clk) begin
    if (rst) begin
      mask       <= '0;
      last_fused <= '0;
      for (int i = 0; i < 3; i++) ema[i] <= '0;
    end else begin
      if (cfg_wr_en) mask <= cfg_wr_data;
      if (cmd.ema_upd) begin
        for (int i = 0; i < 3; i++) begin
          if (mask[i]) ema[i] <= (ema[i] == '0) ? samp[i] : dvd[i];
        end
      end
      if (cmd.out_load && (wsum != '0)) last_fused <= qdvd;
    end
  end

  always_ff @(posedge clk) begin
    // divide by ten: dividend registered, then one reciprocal multiply
    for (int i = 0; i < 3; i++) begin
      if (cmd.load) begin
        samp[i]  <= smp_in[i];
        dnd_q[i] <= dnd[i];
      end else if (cmd.div10_step) begin
        dvd[i] <= rprod[i][RSH +: PW];
      end
    end
    if (cmd.weigh) begin
      med <= med_c;
      for (int i = 0; i < 3; i++) wgt[i] <= wgt_c[i];
    end
    if (cmd.prod) begin
      for (int i = 0; i < 3; i++) prod[i] <= {{WW{1'b0}}, ema[i]} * {{PW{1'b0}}, wgt[i]};
      wsum <= SW'(wgt[0]) + SW'(wgt[1]) + SW'(wgt[2]);
    end
    if (cmd.sum) acc <= AW'(prod[0]) + AW'(prod[1]) + AW'(prod[2]);
    // mean never exceeds the largest EMA, so acc >> PW is already below wsum
    if (cmd.divw_init) begin
      qrem <= acc[AW-1:PW];
      qdvd <= acc[PW-1:0];
    end else if (cmd.divw_step) begin
      qrem <= gew ? SW'(tw - {1'b0, wsum}) : tw[SW-1:0];
      qdvd <= {qdvd[PW-2:0], gew};
    end
    if (cmd.out_load) begin
      fused_value     <= (wsum != '0) ? qdvd : last_fused;
      fused_updated   <= (wsum != '0);
      median_pressure <= med;
      weight_a        <= wgt[0];
      weight_b        <= wgt[1];
      weight_c        <= wgt[2];
    end
  end

endmodule
`default_nettype wire

// ----- src/triple_baro_median_weighted_fusion_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An input transaction runs through divide by ten, EMA update, weighting,
//   products, sum, divider load and the bit-serial weighted-mean divide
//   (skipped, holding the last fused value, when every weight is zero).
//   No new transaction is taken until the result is loaded for output.
// A finished result waits in the output register while the next item runs.
// Reset (rst, synchronous): EMAs, held fused value and enable mask cleared.
// ----------------------------------------------------------------------------
// triple_baro_median_weighted_fusion_core
// Fuses three barometer streams: per-sensor EMA, median, distance-based
// weights and a truncated weighted mean.
// ----------------------------------------------------------------------------
module triple_baro_median_weighted_fusion_core #(
  parameter int PRESSURE_WIDTH = 17
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [2:0]                cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [PRESSURE_WIDTH-1:0] pressure_a,
  input  wire logic [PRESSURE_WIDTH-1:0] pressure_b,
  input  wire logic [PRESSURE_WIDTH-1:0] pressure_c,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [PRESSURE_WIDTH-1:0]      fused_value,
  output logic [PRESSURE_WIDTH-1:0]      median_pressure,
  output logic [6:0]                     weight_a,
  output logic [6:0]                     weight_b,
  output logic [6:0]                     weight_c,
  output logic                           fused_updated
);

  tbmwf_pkg::dp_cmd_t cmd;
  tbmwf_pkg::dp_sts_t sts;

  tbmwf_ctrl #(
    .PRESSURE_WIDTH (PRESSURE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  tbmwf_dp #(
    .PRESSURE_WIDTH (PRESSURE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .pressure_a      (pressure_a),
    .pressure_b      (pressure_b),
    .pressure_c      (pressure_c),
    .cmd             (cmd),
    .sts             (sts),
    .fused_value     (fused_value),
    .median_pressure (median_pressure),
    .weight_a        (weight_a),
    .weight_b        (weight_b),
    .weight_c        (weight_c),
    .fused_updated   (fused_updated)
  );

endmodule
`default_nettype wire

// ----- src/tbmwf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbmwf_checker
// Port-level checks of the fusion core, bound to the top level.
// ----------------------------------------------------------------------------
module tbmwf_checker #(
  parameter int PRESSURE_WIDTH = 17
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [PRESSURE_WIDTH-1:0] fused_value,
  input wire logic [6:0]                weight_a,
  input wire logic [6:0]                weight_b,
  input wire logic [6:0]                weight_c,
  input wire logic                      fused_updated
);

  // a held result must not move under stall
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fused_value))
    else $error("result changed while stalled");

  // one item at a time: busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  // recompute flag agrees with the weights
  a_upd_matches_weights: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fused_updated == ((weight_a | weight_b | weight_c) != 7'd0))
    else $error("fused_updated disagrees with weights");

  a_weight_a_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weight_a == 7'd0 || weight_a == 7'd30 ||
                   weight_a == 7'd70 || weight_a == 7'd100))
    else $error("illegal weight on sensor one");

endmodule

bind triple_baro_median_weighted_fusion_core tbmwf_checker #(
  .PRESSURE_WIDTH (PRESSURE_WIDTH)
) u_tbmwf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .fused_value    (fused_value),
  .weight_a       (weight_a),
  .weight_b       (weight_b),
  .weight_c       (weight_c),
  .fused_updated  (fused_updated)
);
`default_nettype wire
